// ===== hdl/clock_chime_sequencer_core_defines.svh =====
// Assertion helpers for the chime sequencer.
`ifndef CLOCK_CHIME_SEQUENCER_CORE_DEFINES_SVH
`define CLOCK_CHIME_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CCS_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define CCS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/ccs_pkg.sv =====
package ccs_pkg;

   localparam int MaxTuneLen = 30;
   localparam int DelayBeats = 2;

   localparam logic [2:0] NoteRest = 3'd7;
   localparam logic [1:0] RegChimeMode = 2'd0;

   typedef enum logic [1:0] {
      MODE_REGULAR     = 2'd0,
      MODE_WESTMINSTER = 2'd1,
      MODE_HALF_HOUR   = 2'd2,
      MODE_HOUR_ONLY   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_TUNE   = 2'd0,
      PH_DELAY  = 2'd1,
      PH_STRIKE = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      TMR_LEAVE        = 3'd0,
      TMR_STOP         = 3'd1,
      TMR_START_SHORT  = 3'd2,
      TMR_START_BEAT   = 3'd3,
      TMR_START_STRIKE = 3'd4
   } timer_cmd_type;

   typedef enum logic [1:0] {
      STRIKE_NONE   = 2'd0,
      STRIKE_SINGLE = 2'd1,
      STRIKE_CHORD  = 2'd2
   } strike_type;

   localparam logic OpMinute = 1'b0;
   localparam logic OpFire   = 1'b1;

   typedef struct packed {
      logic       op;
      logic [5:0] minute_now;
      logic [4:0] hour_now;
      logic       silenced;
      logic       muted;
   } item_type;

   typedef struct packed {
      strike_type    strike;
      logic [2:0]    bell;
      logic [2:0]    bell_second;
      timer_cmd_type timer_cmd;
      logic          strike_period;
      logic          ringing;
   } result_type;

   typedef struct packed {
      logic       busy;
      phase_type  phase;
      logic [3:0] tune_select;
      logic [4:0] note_position;
      logic       hour_pending;
      logic [3:0] strikes_left;
      logic [1:0] delay_left;
      logic       westminster_chord;
   } state_type;

   function automatic logic [4:0] tune_length(input logic [3:0] sel);
      logic [4:0] n;
      case (sel)
         4'd0: n = 5'd4;
         4'd1: n = 5'd5;
         4'd2: n = 5'd6;
         4'd3: n = 5'd5;
         4'd4: n = 5'd4;
         4'd5: n = 5'd9;
         4'd6: n = 5'd14;
         4'd7: n = 5'd19;
         4'd8: n = 5'd1;
         default: n = 5'd0;
      endcase
      if (int'(n) > MaxTuneLen) begin
         n = 5'(MaxTuneLen);
      end
      return n;
   endfunction

   // Slots past a tune's end read as note 0, as in the stored tune rows.
   function automatic logic [2:0] tune_note(input logic [3:0] sel, input logic [4:0] pos);
      logic [2:0] n;
      n = 3'd0;
      case (sel)
         4'd0: case (pos)
            5'd0: n = 3'd2; 5'd1: n = 3'd2; 5'd2: n = NoteRest; default: n = 3'd0;
         endcase
         4'd1: case (pos)
            5'd0: n = 3'd1; 5'd1: n = 3'd1; 5'd2: n = NoteRest; 5'd4: n = 3'd2;
            default: n = 3'd0;
         endcase
         4'd2: case (pos)
            5'd2: n = NoteRest; 5'd3: n = 3'd2; 5'd4: n = 3'd1; 5'd5: n = 3'd2;
            default: n = 3'd0;
         endcase
         4'd3: case (pos)
            5'd0: n = 3'd2; 5'd1: n = 3'd1; 5'd2: n = 3'd2; 5'd3: n = 3'd1;
            default: n = 3'd0;
         endcase
         4'd4: case (pos)
            5'd0: n = 3'd3; 5'd1: n = 3'd2; 5'd2: n = 3'd1; default: n = 3'd0;
         endcase
         4'd5: case (pos)
            5'd0: n = 3'd1; 5'd1: n = 3'd3; 5'd2: n = 3'd2; 5'd4: n = NoteRest;
            5'd5: n = 3'd1; 5'd6: n = 3'd2; 5'd7: n = 3'd3; 5'd8: n = 3'd1;
            default: n = 3'd0;
         endcase
         4'd6: case (pos)
            5'd0: n = 3'd3; 5'd1: n = 3'd1; 5'd2: n = 3'd2; 5'd4: n = NoteRest;
            5'd6: n = 3'd2; 5'd7: n = 3'd3; 5'd8: n = 3'd1; 5'd9: n = NoteRest;
            5'd10: n = 3'd3; 5'd11: n = 3'd2; 5'd12: n = 3'd1;
            default: n = 3'd0;
         endcase
         4'd7: case (pos)
            5'd0: n = 3'd1; 5'd1: n = 3'd3; 5'd2: n = 3'd2; 5'd4: n = NoteRest;
            5'd5: n = 3'd1; 5'd6: n = 3'd2; 5'd7: n = 3'd3; 5'd8: n = 3'd1;
            5'd9: n = NoteRest; 5'd10: n = 3'd3; 5'd11: n = 3'd1; 5'd12: n = 3'd2;
            5'd14: n = NoteRest; 5'd16: n = 3'd2; 5'd17: n = 3'd3; 5'd18: n = 3'd1;
            default: n = 3'd0;
         endcase
         4'd8: case (pos)
            5'd0: n = 3'd1; default: n = 3'd0;
         endcase
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hdl/clock_chime_sequencer_core.sv =====
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    op, minute_now, hour_now, silenced, muted
// rsp       out        rsp_valid / rsp_stall    strike, bell, bell_second, timer_cmd,
//                                               strike_period, ringing
// csr       in         psel / penable / pready  paddr, pwdata, prdata (chime_mode)
//
// One item per cycle while rsp is not stalled; each accepted item gives one result, passing
// through the input register and then the result register, with the sequence state updated
// as it moves on. A stalled result holds the input register, which then stalls req.
// Synchronous reset clears the sequence state, chime_mode and both valid flags.
`include "clock_chime_sequencer_core_defines.svh"

module clock_chime_sequencer_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [5:0]  req_minute_now,
   input  logic [4:0]  req_hour_now,
   input  logic        req_silenced,
   input  logic        req_muted,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_strike,
   output logic [2:0]  rsp_bell,
   output logic [2:0]  rsp_bell_second,
   output logic [2:0]  rsp_timer_cmd,
   output logic        rsp_strike_period,
   output logic        rsp_ringing,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ccs_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   state_type  state_ff, state_next;
   result_type step_res;
   mode_type   mode_ff;
   logic       advance, req_take, csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[1:0] == {RegChimeMode[1:0]}) ? {30'd0, mode_ff} : 32'd0;

   // The input register moves on whenever the result register is free or being taken.
   assign advance      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ccs_step u_step (
      .mode (mode_ff),
      .item (s1_item_ff),
      .cur  (state_ff),
      .nxt  (state_next),
      .res  (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         mode_ff      <= MODE_REGULAR;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
         if (csr_write) begin
            mode_ff <= mode_type'(pwdata[1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= '{op: req_op, minute_now: req_minute_now, hour_now: req_hour_now,
                         silenced: req_silenced, muted: req_muted};
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_strike        = out_ff.strike;
   assign rsp_bell          = out_ff.bell;
   assign rsp_bell_second   = out_ff.bell_second;
   assign rsp_timer_cmd     = out_ff.timer_cmd;
   assign rsp_strike_period = out_ff.strike_period;
   assign rsp_ringing       = out_ff.ringing;

   `CCS_ASSERT_NOW(a_stall_only_when_blocked, clock, reset, req_stall, s1_valid_ff && out_valid_ff && rsp_stall, "input stalled while the result path was free")
   `CCS_ASSERT_NOW(a_strike_keeps_ringing, clock, reset, out_valid_ff && out_ff.strike != STRIKE_NONE, out_ff.ringing, "a bell was struck by a step that ended the sequence")
   `CCS_ASSERT_NOW(a_stop_ends_ringing, clock, reset, out_valid_ff && out_ff.timer_cmd == TMR_STOP, !out_ff.ringing, "timer stopped while the sequence is still running")
   `CCS_ASSERT_NEXT(a_state_holds_idle, clock, reset, !advance, state_ff == $past(state_ff), "sequence state changed without a transfer")

endmodule

// ===== hdl/ccs_step.sv =====
module ccs_step (
   input  ccs_pkg::mode_type   mode,
   input  ccs_pkg::item_type   item,
   input  ccs_pkg::state_type  cur,
   output ccs_pkg::state_type  nxt,
   output ccs_pkg::result_type res
);
   import ccs_pkg::*;

   logic       is_hour, is_half, is_q1, is_q3;
   logic [1:0] which;
   logic [4:0] len;
   logic [2:0] note;
   logic [4:0] hour_mod;
   logic [3:0] hour_strikes;

   assign is_hour = item.minute_now == 6'd0;
   assign is_half = item.minute_now == 6'd30;
   assign is_q1   = item.minute_now == 6'd15;
   assign is_q3   = item.minute_now == 6'd45;
   assign which   = is_q1 ? 2'd0 : (is_q3 ? 2'd2 : (is_half ? 2'd1 : 2'd3));
   assign len     = tune_length(cur.tune_select);
   assign note    = tune_note(cur.tune_select, cur.note_position);

   // Twelve-hour form: input stays below 32, so two folds are enough.
   always_comb begin
      if (item.hour_now >= 5'd24) begin
         hour_mod = item.hour_now - 5'd24;
      end else if (item.hour_now >= 5'd12) begin
         hour_mod = item.hour_now - 5'd12;
      end else begin
         hour_mod = item.hour_now;
      end
      hour_strikes = (hour_mod == 5'd0) ? 4'd12 : hour_mod[3:0];
   end

   always_comb begin
      logic [1:0] cmd_strike;
      nxt = cur;
      res.strike = STRIKE_NONE;
      res.bell = 3'd0;
      res.bell_second = 3'd0;
      res.timer_cmd = TMR_LEAVE;
      cmd_strike = 2'd0;
      if (item.op == OpMinute) begin
         if (!item.silenced && !cur.busy && (is_hour || is_half || is_q1 || is_q3)) begin
            nxt.westminster_chord = mode == MODE_WESTMINSTER;
            if (mode == MODE_REGULAR || mode == MODE_WESTMINSTER ||
                (mode == MODE_HALF_HOUR && (is_half || is_hour)) || mode == MODE_HOUR_ONLY) begin
               nxt.busy = 1'b1;
               nxt.phase = PH_TUNE;
               nxt.note_position = 5'd0;
               nxt.hour_pending = is_hour;
               res.timer_cmd = TMR_START_SHORT;
               case (mode)
                  MODE_REGULAR:     nxt.tune_select = {2'b00, which};
                  MODE_WESTMINSTER: nxt.tune_select = {2'b01, which};
                  MODE_HALF_HOUR:   nxt.tune_select = is_half ? 4'd8 : 4'd9;
                  default:          nxt.tune_select = 4'd9;
               endcase
            end
         end
      end else if (cur.busy) begin
         unique case (cur.phase)
            PH_TUNE: begin
               if (cur.note_position >= len) begin
                  if (cur.hour_pending) begin
                     nxt.strikes_left = hour_strikes;
                     nxt.hour_pending = 1'b0;
                     if (mode == MODE_HOUR_ONLY) begin
                        nxt.phase = PH_STRIKE;
                        res.timer_cmd = TMR_START_STRIKE;
                     end else begin
                        nxt.phase = PH_DELAY;
                        nxt.delay_left = 2'(DelayBeats);
                        res.timer_cmd = TMR_START_BEAT;
                     end
                  end else begin
                     nxt.busy = 1'b0;
                     res.timer_cmd = TMR_STOP;
                  end
               end else begin
                  if (note != NoteRest && !item.muted) begin
                     res.strike = STRIKE_SINGLE;
                     res.bell = note;
                  end
                  nxt.note_position = cur.note_position + 5'd1;
               end
            end
            PH_DELAY: begin
               if (cur.delay_left <= 2'd1) begin
                  nxt.delay_left = 2'd0;
                  nxt.phase = PH_STRIKE;
                  res.timer_cmd = TMR_START_STRIKE;
               end else begin
                  nxt.delay_left = cur.delay_left - 2'd1;
               end
            end
            PH_STRIKE: begin
               if (cur.strikes_left == 4'd0) begin
                  nxt.busy = 1'b0;
                  res.timer_cmd = TMR_STOP;
               end else begin
                  if (!item.muted) begin
                     res.strike = STRIKE_CHORD;
                     res.bell = cur.westminster_chord ? 3'd1 : 3'd2;
                  end
                  nxt.strikes_left = cur.strikes_left - 4'd1;
               end
            end
            default: begin
               nxt.busy = 1'b0;
               nxt.phase = PH_TUNE;
               res.timer_cmd = TMR_STOP;
            end
         endcase
      end
      cmd_strike = 2'(nxt.westminster_chord);
      res.strike_period = cmd_strike[0];
      res.ringing = nxt.busy;
   end

endmodule
